// ----- hw/rtl/bounding_sphere_grow_unit_defines.svh -----
// Assertion macros for the bounding sphere grow unit
`ifndef BOUNDING_SPHERE_GROW_UNIT_DEFINES_SVH
`define BOUNDING_SPHERE_GROW_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define BSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define BSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BSG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/bsg_pkg.sv -----
package bsg_pkg;
  localparam int CoordBits = 24;
  localparam int RadBits   = CoordBits + 1;
  localparam int DiffBits  = CoordBits + 1;
  localparam int SqBits    = 2 * DiffBits + 2;
  localparam int RootBits  = SqBits / 2;
  localparam int ProdBits  = RadBits + DiffBits;
  localparam int CntBits   = 6;

  // Datapath commands from the controller
  typedef struct packed {
    logic load;
    logic diff;
    logic sq_start;
    logic sq_step;
    logic check;
    logic rnew;
    logic axis_start;
    logic div_step;
    logic axis_done;
  } bsg_cmd_t;

  typedef struct packed {
    logic outside;
    logic is_load;
  } bsg_sts_t;
endpackage

// ----- hw/rtl/bsg_ctrl.sv -----
module bsg_ctrl import bsg_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  bsg_sts_t sts_i,
  output bsg_cmd_t cmd_o
);
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDiff = 4'd1;
  localparam logic [3:0] StSqIn = 4'd2;
  localparam logic [3:0] StSq   = 4'd3;
  localparam logic [3:0] StChk  = 4'd4;
  localparam logic [3:0] StFix  = 4'd5;
  localparam logic [3:0] StRnew = 4'd6;
  localparam logic [3:0] StAxIn = 4'd7;
  localparam logic [3:0] StDiv  = 4'd8;
  localparam logic [3:0] StAxEn = 4'd9;
  localparam logic [3:0] StOut  = 4'd10;
  localparam logic [3:0] StDec  = 4'd11;

  logic [3:0] state_q, state_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [1:0] axis_q, axis_d;
  logic ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == StIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;

  // Sequencer
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; axis_d = axis_q; ovalid_d = ovalid_q;
    cmd_o = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1; state_d = StDec;
        end
      end
      StDec: state_d = sts_i.is_load ? StOut : StDiff;
      StDiff: begin cmd_o.diff = 1'b1; state_d = StSqIn; end
      StSqIn: begin
        cmd_o.sq_start = 1'b1; cnt_d = CntBits'(RootBits - 1); state_d = StSq;
      end
      StSq: begin
        cmd_o.sq_step = 1'b1;
        if (cnt_q == '0) state_d = StChk; else cnt_d = cnt_q - 1'b1;
      end
      StChk: begin
        cmd_o.check = 1'b1; state_d = StFix;
      end
      StFix: begin
        if (sts_i.outside) state_d = StRnew;
        else state_d = StOut;
      end
      StRnew: begin cmd_o.rnew = 1'b1; axis_d = 2'd0; state_d = StAxIn; end
      StAxIn: begin
        cmd_o.axis_start = 1'b1; cnt_d = CntBits'(ProdBits - 1); state_d = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) state_d = StAxEn; else cnt_d = cnt_q - 1'b1;
      end
      StAxEn: begin
        cmd_o.axis_done = 1'b1;
        if (axis_q == 2'd2) state_d = StOut;
        else begin axis_d = axis_q + 1'b1; state_d = StAxIn; end
      end
      StOut: begin ovalid_d = 1'b1; state_d = StIdle; end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; cnt_q <= '0; axis_q <= '0; ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; axis_q <= axis_d; ovalid_q <= ovalid_d;
    end
  end
endmodule

// ----- hw/rtl/bsg_dpath.sv -----
module bsg_dpath import bsg_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bsg_cmd_t                    cmd_i,
  input  logic                        action_i,
  input  logic signed [CoordBits-1:0] pos_x_i,
  input  logic signed [CoordBits-1:0] pos_y_i,
  input  logic signed [CoordBits-1:0] pos_z_i,
  input  logic [RadBits-1:0]          load_radius_i,
  output bsg_sts_t                    sts_o,
  output logic signed [CoordBits-1:0] out_x_o,
  output logic signed [CoordBits-1:0] out_y_o,
  output logic signed [CoordBits-1:0] out_z_o,
  output logic [RadBits-1:0]          out_radius_o,
  output logic                        grew_o
);
  localparam int RemBits = RootBits + 2;
  localparam logic signed [ProdBits+1:0] MovMax =
    (ProdBits+2)'((64'sd1 <<< (CoordBits - 1)) - 64'sd1);
  localparam logic signed [ProdBits+1:0] MovMin = ~MovMax;

  logic signed [CoordBits-1:0] ctr_q [3];
  logic [RadBits-1:0] rad_q;
  logic grew_q, act_q, out_q;
  logic signed [CoordBits-1:0] p_q [3];
  logic signed [DiffBits-1:0] d_q [3];
  logic [SqBits-1:0] d2_q, sqv_q;
  logic [RootBits-1:0] root_q;
  logic [RemBits-1:0] rem_q;
  logic [RootBits-1:0] dist_q;
  logic [RadBits-1:0] t_q;
  logic [1:0] ax_q;
  logic [ProdBits-1:0] num_q, quo_q;
  logic [RootBits:0] drem_q;
  logic neg_q;

  // Squares of the offsets
  logic [DiffBits-1:0] a0, a1, a2;
  logic [SqBits-1:0] sum_sq;
  always_comb begin
    a0 = d_q[0][DiffBits-1] ? DiffBits'(-d_q[0]) : DiffBits'(d_q[0]);
    a1 = d_q[1][DiffBits-1] ? DiffBits'(-d_q[1]) : DiffBits'(d_q[1]);
    a2 = d_q[2][DiffBits-1] ? DiffBits'(-d_q[2]) : DiffBits'(d_q[2]);
    sum_sq = SqBits'(a0 * a0) + SqBits'(a1 * a1) + SqBits'(a2 * a2);
  end

  // Restoring square root step, two bits a cycle
  logic [RemBits-1:0] trial, rem_sh;
  always_comb begin
    rem_sh = {rem_q[RemBits-3:0], sqv_q[SqBits-1 -: 2]};
    trial  = {root_q, 2'b01};
  end

  // Rounded-division operand: magnitude plus half divisor
  logic signed [DiffBits-1:0] dsel;
  logic [DiffBits-1:0] dmag;
  logic [ProdBits-1:0] prod;
  logic [RootBits:0] drem_sh;
  always_comb begin
    dsel = d_q[ax_q];
    dmag = dsel[DiffBits-1] ? DiffBits'(-dsel) : DiffBits'(dsel);
    prod = ProdBits'(t_q) * ProdBits'(dmag);
    drem_sh = {drem_q[RootBits-1:0], num_q[ProdBits-1]};
  end

  // New coordinate with saturation
  logic signed [ProdBits+1:0] moved;
  logic signed [CoordBits-1:0] sat;
  always_comb begin
    moved = (ProdBits+2)'(ctr_q[ax_q]) +
            (neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
    if (moved > MovMax)
      sat = {1'b0, {(CoordBits-1){1'b1}}};
    else if (moved < MovMin)
      sat = {1'b1, {(CoordBits-1){1'b0}}};
    else sat = moved[CoordBits-1:0];
  end

  // New radius, saturated to the field width
  logic [2*RadBits-1:0] rsq;
  logic [RootBits+1:0] rsum;
  logic [RadBits-1:0] rnew_sat;
  assign rsq  = rad_q * rad_q;
  assign rsum = (RootBits+2)'(rad_q) + (RootBits+2)'(dist_q) + 1'b1;
  assign rnew_sat = (rsum[RootBits+1:1] > (RootBits+1)'({RadBits{1'b1}})) ?
                    {RadBits{1'b1}} : RadBits'(rsum[RootBits+1:1]);

  // Sphere state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q[0] <= '0; ctr_q[1] <= '0; ctr_q[2] <= '0; rad_q <= '0; grew_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        grew_q <= 1'b0;
        if (!action_i) begin
          ctr_q[0] <= pos_x_i; ctr_q[1] <= pos_y_i; ctr_q[2] <= pos_z_i;
          rad_q <= load_radius_i;
        end
      end
      if (cmd_i.rnew) begin
        grew_q <= 1'b1;
        rad_q  <= rnew_sat;
      end
      if (cmd_i.axis_done) ctr_q[ax_q] <= sat;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i; p_q[0] <= pos_x_i; p_q[1] <= pos_y_i; p_q[2] <= pos_z_i;
      ax_q <= 2'd0;
    end
    if (cmd_i.diff)
      for (int i = 0; i < 3; i++)
        d_q[i] <= DiffBits'(p_q[i]) - DiffBits'(ctr_q[i]);
    if (cmd_i.sq_start) begin
      d2_q <= sum_sq; sqv_q <= sum_sq; root_q <= '0; rem_q <= '0;
    end
    if (cmd_i.sq_step) begin
      sqv_q <= sqv_q << 2;
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial; root_q <= {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh; root_q <= {root_q[RootBits-2:0], 1'b0};
      end
    end
    if (cmd_i.check) begin
      out_q  <= SqBits'(rsq) < d2_q;
      dist_q <= (rem_q != '0) ? root_q + 1'b1 : root_q;
    end
    if (cmd_i.rnew) t_q <= rnew_sat - rad_q;
    if (cmd_i.axis_start) begin
      neg_q  <= dsel[DiffBits-1];
      num_q  <= prod + ProdBits'(dist_q >> 1);
      quo_q  <= '0; drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      num_q <= num_q << 1;
      if (drem_sh >= {1'b0, dist_q}) begin
        drem_q <= drem_sh - {1'b0, dist_q}; quo_q <= {quo_q[ProdBits-2:0], 1'b1};
      end else begin
        drem_q <= drem_sh; quo_q <= {quo_q[ProdBits-2:0], 1'b0};
      end
    end
    if (cmd_i.axis_done) ax_q <= ax_q + 1'b1;
  end

  assign sts_o.outside = out_q;
  assign sts_o.is_load = !act_q;
  assign out_x_o = ctr_q[0];
  assign out_y_o = ctr_q[1];
  assign out_z_o = ctr_q[2];
  assign out_radius_o = rad_q;
  assign grew_o = grew_q;
endmodule

// ----- hw/rtl/bounding_sphere_grow_unit.sv -----
// Bounding sphere grow unit: one item in flight at a time.
// A load item goes from StDec straight to StOut; a grow item runs the offsets, the
// 2-bit-a-cycle square root and the inside check, and if outside, the new radius and
// the radix-2 divider shared over the three axes.
// Next item accepted the cycle after the result is taken.
// Reset (rst_ni low, asynchronous) clears the center and radius to zero.
`include "bounding_sphere_grow_unit_defines.svh"
module bounding_sphere_grow_unit import bsg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,  // pos_x, pos_y, pos_z, load_radius, zero fill
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,  // out_x, out_y, out_z, out_radius, zero fill
  output logic         m_axis_tuser   // grew
);
  bsg_cmd_t cmd;
  bsg_sts_t sts;
  logic signed [CoordBits-1:0] ox, oy, oz;
  logic [RadBits-1:0] orad;
  logic ogrew;

  bsg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .sts_i(sts), .cmd_o(cmd)
  );

  bsg_dpath u_dpath (
    .clk_i, .rst_ni, .cmd_i(cmd), .action_i(s_axis_tuser),
    .pos_x_i(s_axis_tdata[23:0]), .pos_y_i(s_axis_tdata[47:24]),
    .pos_z_i(s_axis_tdata[71:48]), .load_radius_i(s_axis_tdata[96:72]),
    .sts_o(sts), .out_x_o(ox), .out_y_o(oy), .out_z_o(oz),
    .out_radius_o(orad), .grew_o(ogrew)
  );

  assign m_axis_tdata = {7'd0, orad, oz, oy, ox};
  assign m_axis_tuser = ogrew;

  `BSG_ASSERT_IMPL(a_rdy_out, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "ready with result")
  `BSG_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "busy")
  `BSG_ASSERT_IMPL(a_grew_load, clk_i, rst_ni, m_axis_tvalid && ogrew, !cmd.load, "grew on load")
endmodule

// ----- dv/tb_bounding_sphere_grow_unit.sv -----
`timescale 1ns / 100ps
module tb_bounding_sphere_grow_unit;
  import bsg_pkg::*;

  localparam longint CoordMax = (64'sd1 <<< (CoordBits - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  localparam longint RadMax   = (64'sd1 <<< RadBits) - 1;
  localparam logic   ActLoad  = 1'b0;
  localparam logic   ActGrow  = 1'b1;
  localparam int     ExpDepth = 16;

  typedef struct {
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [CoordBits-1:0] cz;
    logic [RadBits-1:0]          rad;
    logic                        grew;
  } sphere_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tuser;

  // Sphere tracked alongside the block
  longint  mdl_c[3] = '{0, 0, 0};
  longint  mdl_r = 0;
  sphere_t exp_mem[ExpDepth];
  int      exp_wr = 0;
  int      exp_rd = 0;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      err_cnt = 0;

  bounding_sphere_grow_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  // Quotient rounded to nearest, ties away from zero
  function automatic longint div_nearest(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + (den >>> 1)) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  // Update the tracked sphere for one item and queue the expected result
  function automatic void predict_sphere(logic act, longint px, longint py, longint pz,
                                         longint lrad);
    longint  p[3];
    longint  d[3];
    longint  d2;
    longint  dist_v;
    longint  rnew;
    longint  t;
    longint  v;
    sphere_t e;
    p[0] = px; p[1] = py; p[2] = pz;
    e.grew = 1'b0;
    if (act == ActLoad) begin
      for (int i = 0; i < 3; i++) mdl_c[i] = p[i];
      mdl_r = lrad;
    end else begin
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = p[i] - mdl_c[i];
        d2 += d[i] * d[i];
      end
      if (mdl_r * mdl_r < d2) begin
        dist_v = longint'(sqrt_floor(longint'(d2)));
        if (dist_v * dist_v < d2) dist_v++;
        rnew = (mdl_r + dist_v + 1) >>> 1;
        if (rnew > RadMax) rnew = RadMax;
        t = rnew - mdl_r;
        for (int i = 0; i < 3; i++) begin
          v = mdl_c[i] + div_nearest(t * d[i], dist_v);
          if (v > CoordMax) v = CoordMax;
          if (v < CoordMin) v = CoordMin;
          mdl_c[i] = v;
        end
        mdl_r = rnew;
        e.grew = 1'b1;
      end
    end
    e.cx = mdl_c[0][CoordBits-1:0];
    e.cy = mdl_c[1][CoordBits-1:0];
    e.cz = mdl_c[2][CoordBits-1:0];
    e.rad = mdl_r[RadBits-1:0];
    exp_mem[exp_wr % ExpDepth] = e;
    exp_wr++;
  endfunction

  // Input side: predict on accept. Output side: compare on accept.
  always @(posedge clk_i) begin
    sphere_t e;
    logic [103:0] din;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      din = s_axis_tdata;
      predict_sphere(s_axis_tuser, longint'($signed(din[23:0])),
                     longint'($signed(din[47:24])), longint'($signed(din[71:48])),
                     longint'(din[96:72]));
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result item");
        err_cnt++;
      end else begin
        e = exp_mem[exp_rd % ExpDepth];
        exp_rd++;
        if (m_axis_tdata[23:0] !== e.cx) begin
          $error("out_x exp %0d got %0d", e.cx, $signed(m_axis_tdata[23:0]));
          err_cnt++;
        end
        if (m_axis_tdata[47:24] !== e.cy) begin
          $error("out_y exp %0d got %0d", e.cy, $signed(m_axis_tdata[47:24]));
          err_cnt++;
        end
        if (m_axis_tdata[71:48] !== e.cz) begin
          $error("out_z exp %0d got %0d", e.cz, $signed(m_axis_tdata[71:48]));
          err_cnt++;
        end
        if (m_axis_tdata[96:72] !== e.rad) begin
          $error("out_radius exp %0d got %0d", e.rad, m_axis_tdata[96:72]);
          err_cnt++;
        end
        if (m_axis_tuser !== e.grew) begin
          $error("grew exp %0d got %0d", e.grew, m_axis_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Receiver stalls
  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_item(logic act, longint px, longint py, longint pz, longint lrad);
    logic [103:0] pkt;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    pkt = '0;
    pkt[23:0]  = px[CoordBits-1:0];
    pkt[47:24] = py[CoordBits-1:0];
    pkt[71:48] = pz[CoordBits-1:0];
    pkt[96:72] = lrad[RadBits-1:0];
    s_axis_tdata  = pkt;
    s_axis_tuser  = act;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic longint clamp_coord(longint v);
    return (v > CoordMax) ? CoordMax : ((v < CoordMin) ? CoordMin : v);
  endfunction

  function automatic longint rand_coord();
    return longint'($signed(24'($urandom)));
  endfunction

  task automatic test_directed();
    longint r;
    // Extremes of the fields on load
    send_item(ActLoad, CoordMax, CoordMin, 0, RadMax);
    send_item(ActLoad, CoordMin, CoordMax, -1, 0);
    // Grow from the zero sphere, and by the far corner
    send_item(ActGrow, CoordMax, CoordMax, CoordMax, 0);
    send_item(ActLoad, CoordMin, CoordMin, CoordMin, 0);
    send_item(ActGrow, CoordMax, CoordMax, CoordMax, 0);
    send_item(ActGrow, CoordMin, CoordMax, CoordMin, RadMax);
    // Point on the surface counts as inside
    r = 1000;
    send_item(ActLoad, 100, -200, 300, r);
    send_item(ActGrow, 100 + r, -200, 300, 0);
    send_item(ActGrow, 100, -200 - r, 300, 0);
    send_item(ActGrow, 100 + 600, -200 + 800, 300, 0);
    // Just outside, then the original center
    send_item(ActGrow, 100, -200, 300 + r + 1, 0);
    send_item(ActGrow, 100, -200, 300, 0);
    // Odd sums and rounding ties
    send_item(ActLoad, 0, 0, 0, 1);
    send_item(ActGrow, 3, 0, 0, 0);
    send_item(ActGrow, -7, 5, 1, 0);
    send_item(ActGrow, 2, -9, -4, 0);
    // Huge radius keeps everything inside
    send_item(ActLoad, 0, 0, 0, RadMax);
    send_item(ActGrow, CoordMin, CoordMin, CoordMin, 0);
  endtask

  task automatic test_random(int n);
    longint cx, cy, cz, r, sc;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 12) begin
        sc = 1 << $urandom_range(23);
        cx = longint'($urandom_range(32'(2 * sc))) - sc;
        cy = longint'($urandom_range(32'(2 * sc))) - sc;
        cz = longint'($urandom_range(32'(2 * sc))) - sc;
        r = ($urandom_range(9) == 0) ? longint'(25'($urandom))
                                    : longint'($urandom_range(32'(sc)));
        send_item(ActLoad, cx, cy, cz, r);
      end else if ($urandom_range(99) < 8) begin
        send_item(ActGrow, rand_coord(), rand_coord(), rand_coord(),
                  longint'(25'($urandom)));
      end else begin
        // Point near the current sphere surface, inside or outside
        sc = mdl_r + 2 + longint'($urandom_range(mdl_r < 64 ? 64 : 32'(mdl_r / 2)));
        if (sc > 4 * CoordMax) sc = 4 * CoordMax;
        cx = clamp_coord(mdl_c[0] + longint'($urandom_range(32'(2 * sc))) - sc);
        cy = clamp_coord(mdl_c[1] + longint'($urandom_range(32'(2 * sc))) - sc);
        cz = clamp_coord(mdl_c[2] + longint'($urandom_range(32'(2 * sc))) - sc);
        send_item(ActGrow, cx, cy, cz, longint'(25'($urandom)));
      end
    end
  endtask

  initial begin
    int wait_cnt;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = ActLoad;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 35; recv_idle_pct = 71;
    test_directed();
    test_random(660);
    send_idle_pct = 71; recv_idle_pct = 35;
    test_random(660);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(660);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    // Drain outstanding results
    wait_cnt = 0;
    while (exp_wr != exp_rd && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && exp_wr == exp_rd) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
